@@ rtl/swt_pkg.sv @@
// Package for the shell word tokenizer: result and state types, codes and constants.
// Used by swt_step, swt_out and shell_word_tokenizer; depends on nothing.
`timescale 1ns / 1ps

package swt_pkg;

  // most results one request can cause
  localparam int MAX_RES = 3;

  // input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOW  = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  // word modes
  localparam logic [1:0] MODE_GAP  = 2'd0;
  localparam logic [1:0] MODE_BARE = 2'd1;
  localparam logic [1:0] MODE_SQ   = 2'd2;
  localparam logic [1:0] MODE_DQ   = 2'd3;

  // special bytes
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] DELIM_RESET = 8'h20;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [7:0] idx;
    logic       last;
  } res_t;

  typedef res_t [MAX_RES-1:0] bundle_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       quote_pending;
    logic       escape_pending;
    logic       word_has_chars;
    logic [7:0] word_count;
  } state_t;

  // results of one request, handed to the output buffer
  typedef struct packed {
    logic       load;
    logic [1:0] count;
    bundle_t    res;
  } load_t;

  // bytes that a backslash escapes inside double quotes
  function automatic logic dq_escapable(input logic [7:0] b);
    return (b == CH_DOLLAR) || (b == CH_DQUOTE) || (b == CH_BSLASH) || (b == CH_NEWLINE);
  endfunction

endpackage

@@ rtl/swt_step.sv @@
// Next-state and result logic for one request of the shell word tokenizer.
// Purely combinational; depends on swt_pkg.
`timescale 1ns / 1ps

module swt_step (
  input  swt_pkg::state_t  state,
  input  logic [7:0]       delimiter,
  input  logic             op,
  input  logic [7:0]       char_in,
  output swt_pkg::state_t  state_next,
  output swt_pkg::bundle_t res,
  output logic [1:0]       count
);
  import swt_pkg::*;

  // walk the request in model order, appending results at slot k
  always_comb begin
    state_t     s;
    bundle_t    r;
    logic [1:0] k;
    logic [7:0] q;
    logic       done;

    s    = state;
    r    = '0;
    k    = 2'd0;
    done = 1'b0;
    q    = (state.mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;

    if (op == OP_EOL) begin
      // close any open word, then mark end of line
      if (s.mode == MODE_BARE) begin
        r[k] = '{KIND_EOW, 8'd0, s.word_count, 1'b0};
        k = k + 2'd1;
        if (s.word_count != COUNT_MAX) s.word_count = s.word_count + 8'd1;
      end else if (s.mode == MODE_SQ || s.mode == MODE_DQ) begin
        if (s.mode == MODE_DQ && s.escape_pending) begin
          r[k] = '{KIND_CHAR, CH_BSLASH, s.word_count, 1'b0};
          k = k + 2'd1;
          s.word_has_chars = 1'b1;
        end
        if (s.word_has_chars) begin
          r[k] = '{KIND_EOW, 8'd0, s.word_count, 1'b0};
          k = k + 2'd1;
          if (s.word_count != COUNT_MAX) s.word_count = s.word_count + 8'd1;
        end
      end
      r[k] = '{KIND_EOL, 8'd0, s.word_count, 1'b0};
      k = k + 2'd1;
      s = '0;
    end else begin
      // quote seen in quoted mode: doubled quote or closing quote
      if (s.mode[1] && s.quote_pending) begin
        s.quote_pending = 1'b0;
        if (char_in == q) begin
          done = 1'b1;
        end else begin
          if (s.word_has_chars) begin
            r[k] = '{KIND_EOW, 8'd0, s.word_count, 1'b0};
            k = k + 2'd1;
            if (s.word_count != COUNT_MAX) s.word_count = s.word_count + 8'd1;
            s.word_has_chars = 1'b0;
          end
          s.mode = MODE_GAP;
        end
      end
      // escape inside quotes
      if (!done && s.mode[1] && s.escape_pending) begin
        s.escape_pending = 1'b0;
        if (s.mode == MODE_DQ && !dq_escapable(char_in)) begin
          r[k] = '{KIND_CHAR, CH_BSLASH, s.word_count, 1'b0};
          k = k + 2'd1;
        end
        r[k] = '{KIND_CHAR, char_in, s.word_count, 1'b0};
        k = k + 2'd1;
        s.word_has_chars = 1'b1;
        done = 1'b1;
      end
      // escape in a bare word
      if (!done && s.mode == MODE_BARE && s.escape_pending) begin
        s.escape_pending = 1'b0;
        r[k] = '{KIND_CHAR, char_in, s.word_count, 1'b0};
        k = k + 2'd1;
        s.word_has_chars = 1'b1;
        done = 1'b1;
      end
      // between words: skip delimiters, open quoted or bare word
      if (!done && s.mode == MODE_GAP) begin
        if (char_in == delimiter) begin
          done = 1'b1;
        end else if (char_in == CH_SQUOTE) begin
          s.mode = MODE_SQ;
          done = 1'b1;
        end else if (char_in == CH_DQUOTE) begin
          s.mode = MODE_DQ;
          done = 1'b1;
        end else begin
          s.mode = MODE_BARE;
        end
      end
      if (!done) begin
        if (s.mode == MODE_BARE) begin
          // bare word body
          if (char_in == delimiter) begin
            r[k] = '{KIND_EOW, 8'd0, s.word_count, 1'b0};
            k = k + 2'd1;
            if (s.word_count != COUNT_MAX) s.word_count = s.word_count + 8'd1;
            s.word_has_chars = 1'b0;
            s.mode = MODE_GAP;
          end else if (char_in == CH_BSLASH) begin
            s.escape_pending = 1'b1;
          end else if (char_in != CH_SQUOTE && char_in != CH_DQUOTE) begin
            r[k] = '{KIND_CHAR, char_in, s.word_count, 1'b0};
            k = k + 2'd1;
            s.word_has_chars = 1'b1;
          end
        end else begin
          // quoted word body
          if (char_in == q) begin
            s.quote_pending = 1'b1;
          end else if (char_in == CH_BSLASH) begin
            s.escape_pending = 1'b1;
          end else begin
            r[k] = '{KIND_CHAR, char_in, s.word_count, 1'b0};
            k = k + 2'd1;
            s.word_has_chars = 1'b1;
          end
        end
      end
    end

    // flag the final result of this request
    for (int i = 0; i < MAX_RES; i++) begin
      r[i].last = (k != 2'd0) && (2'(i) == k - 2'd1);
    end

    state_next = s;
    res        = r;
    count      = k;
  end

endmodule

@@ rtl/swt_out.sv @@
// Result buffer of the shell word tokenizer: holds the results of one request
// and hands them out one per cycle while out_stall is low. Depends on swt_pkg.
`timescale 1ns / 1ps

module swt_out (
  input  logic           clk,
  input  logic           rst,
  input  swt_pkg::load_t ld,
  input  logic           out_stall,
  output logic           out_valid,
  output swt_pkg::res_t  head,
  output logic           busy
);
  import swt_pkg::*;

  bundle_t    slots;
  logic [1:0] cnt;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = slots[0];
  // cannot take a new request unless at most the head remains and leaves now
  assign busy      = (cnt > 2'd1) || (out_valid && out_stall);

  // result count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (ld.load) begin
      cnt <= ld.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // result slots, shifted toward the head as results leave
  always_ff @(posedge clk) begin
    if (ld.load) begin
      slots <= ld.res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slots[i] <= slots[i+1];
      end
      slots[MAX_RES-1] <= '0;
    end
  end

endmodule

@@ rtl/shell_word_tokenizer.sv @@
// Shell word tokenizer top level: tokenizer state, delimiter register and result buffer.
// Latency: the first result of a request appears the cycle after it is accepted.
// Throughput: one request per cycle while out_stall is low and each causes at most one
// result; a request with more results holds the input until only its last result is left.
// Reset: clears the tokenizer state and the buffer, delimiter returns to 0x20.
`timescale 1ns / 1ps

module shell_word_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] char_out,
  output logic [7:0] word_index,
  output logic       last_of_run
);
  import swt_pkg::*;

  logic [7:0] delimiter;
  state_t     state;
  state_t     state_next;
  bundle_t    res;
  logic [1:0] count;
  load_t      ld;
  res_t       head;
  logic       busy;
  logic       accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (cfg_wr_en) begin
      delimiter <= cfg_wr_data;
    end
  end

  // tokenizer state, advanced once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  swt_step u_step (
    .state      (state),
    .delimiter  (delimiter),
    .op         (op),
    .char_in    (char_in),
    .state_next (state_next),
    .res        (res),
    .count      (count)
  );

  // load the buffer with this request's results
  always_comb begin
    ld.load  = accept;
    ld.count = count;
    ld.res   = res;
  end

  swt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .busy      (busy)
  );

  assign kind        = head.kind;
  assign char_out    = head.ch;
  assign word_index  = head.idx;
  assign last_of_run = head.last;

endmodule
